FILE: design/jaos_pkg.sv
// shared types, codes and constants for the json array object splitter
package jaos_pkg;

    localparam int DEPTH_BITS_DEF = 8;
    localparam int LEN_BITS_DEF   = 16;

    localparam int CFG_W    = 16;
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int PHASE_W  = 2;
    localparam int COPIED_W = 16;

    localparam logic [CFG_W-1:0] MAX_COPY_RESET = 16'd4095;

    localparam logic [PHASE_W-1:0] PH_SCAN  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_OBJ   = 2'd1;
    localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd2;
    localparam logic [PHASE_W-1:0] PH_ENDED = 2'd3;

    localparam logic [KIND_W-1:0] KIND_BYTE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NOMORE = 2'd2;

    localparam logic [BYTE_W-1:0] CH_LBRACE   = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE   = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_QUOTE    = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSLASH   = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_LBRACKET = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_COMMA    = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB      = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF       = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR       = 8'h0D;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              end_of_input;
        logic              restart;
    } item_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               inside_string;
        logic               escape_pending;
        logic               dropped_flag;
    } flags_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [BYTE_W-1:0]   data;
        logic                first;
        logic                last;
        logic [COPIED_W-1:0] copied_length;
        logic                truncated;
        logic                closed_by_brace;
    } result_t;

endpackage

FILE: design/jaos_step.sv
// per-byte parser step: next parser state and optional result for one transaction
module jaos_step #(
    parameter int DEPTH_BITS = jaos_pkg::DEPTH_BITS_DEF,
    parameter int LEN_BITS   = jaos_pkg::LEN_BITS_DEF
) (
    input  jaos_pkg::item_t              item,
    input  logic [jaos_pkg::CFG_W-1:0]   max_copy_len,
    input  jaos_pkg::flags_t             flags,
    input  logic [DEPTH_BITS-1:0]        brace_depth,
    input  logic [LEN_BITS-1:0]          byte_count,
    output jaos_pkg::flags_t             flags_next,
    output logic [DEPTH_BITS-1:0]        brace_depth_next,
    output logic [LEN_BITS-1:0]          byte_count_next,
    output logic                         has_result,
    output jaos_pkg::result_t            result
);

    localparam int CMP_W = (LEN_BITS > jaos_pkg::CFG_W) ? LEN_BITS : jaos_pkg::CFG_W;
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
    localparam logic [LEN_BITS-1:0]   COUNT_MAX = {LEN_BITS{1'b1}};

    jaos_pkg::flags_t          base;
    logic [DEPTH_BITS-1:0]     dep_base;
    logic [LEN_BITS-1:0]       cnt_base;
    logic [LEN_BITS-1:0]       cnt_inc;
    logic [CMP_W-1:0]          cnt_base_ext;
    logic [CMP_W-1:0]          cnt_inc_ext;
    logic [CMP_W-1:0]          max_ext;
    logic                      byte_path;
    logic                      is_first;
    logic                      closes;
    logic                      is_skip;
    logic [jaos_pkg::BYTE_W-1:0] b;

    assign b = item.in_byte;
    assign is_skip = (b == jaos_pkg::CH_SPACE) || (b == jaos_pkg::CH_TAB) ||
                     (b == jaos_pkg::CH_LF) || (b == jaos_pkg::CH_CR) ||
                     (b == jaos_pkg::CH_LBRACKET) || (b == jaos_pkg::CH_COMMA);

    // restart clears parser state before the byte is handled
    always_comb
    begin
        if (item.restart)
        begin
            base.phase          = jaos_pkg::PH_SCAN;
            base.inside_string  = 1'b0;
            base.escape_pending = 1'b0;
            base.dropped_flag   = 1'b0;
            dep_base            = '0;
        end
        else
        begin
            base     = flags;
            dep_base = brace_depth;
        end
    end

    always_comb
    begin
        flags_next       = base;
        brace_depth_next = dep_base;
        byte_count_next  = item.restart ? '0 : byte_count;
        cnt_base         = item.restart ? '0 : byte_count;
        byte_path        = 1'b0;
        is_first         = 1'b0;
        closes           = 1'b0;
        has_result       = 1'b0;
        result           = '0;

        case (base.phase)
            jaos_pkg::PH_IDLE:
            begin
            end
            jaos_pkg::PH_ENDED:
            begin
                flags_next.phase = jaos_pkg::PH_IDLE;
                has_result       = 1'b1;
                result.kind      = jaos_pkg::KIND_NOMORE;
            end
            jaos_pkg::PH_SCAN:
            begin
                if (item.end_of_input || (!is_skip && (b != jaos_pkg::CH_LBRACE)))
                begin
                    flags_next.phase = jaos_pkg::PH_IDLE;
                    has_result       = 1'b1;
                    result.kind      = jaos_pkg::KIND_NOMORE;
                end
                else if (!is_skip)
                begin
                    flags_next.phase          = jaos_pkg::PH_OBJ;
                    flags_next.inside_string  = 1'b0;
                    flags_next.escape_pending = 1'b0;
                    flags_next.dropped_flag   = 1'b0;
                    brace_depth_next          = DEPTH_BITS'(1);
                    cnt_base                  = '0;
                    byte_count_next           = '0;
                    is_first                  = 1'b1;
                    byte_path                 = 1'b1;
                end
            end
            default:
            begin
                if (item.end_of_input)
                begin
                    flags_next.phase      = jaos_pkg::PH_ENDED;
                    has_result            = 1'b1;
                    result.kind           = jaos_pkg::KIND_END;
                    result.last           = 1'b1;
                    result.copied_length  = cnt_base_ext[jaos_pkg::COPIED_W-1:0];
                    result.truncated      = base.dropped_flag;
                end
                else
                begin
                    byte_path = 1'b1;
                    if (base.escape_pending)
                        flags_next.escape_pending = 1'b0;
                    else if (base.inside_string)
                    begin
                        if (b == jaos_pkg::CH_BSLASH)
                            flags_next.escape_pending = 1'b1;
                        else if (b == jaos_pkg::CH_QUOTE)
                            flags_next.inside_string = 1'b0;
                    end
                    else if (b == jaos_pkg::CH_QUOTE)
                        flags_next.inside_string = 1'b1;
                    else if (b == jaos_pkg::CH_LBRACE)
                    begin
                        if (dep_base != DEPTH_MAX)
                            brace_depth_next = dep_base + DEPTH_BITS'(1);
                    end
                    else if (b == jaos_pkg::CH_RBRACE)
                    begin
                        if (dep_base != '0)
                            brace_depth_next = dep_base - DEPTH_BITS'(1);
                        closes = (dep_base <= DEPTH_BITS'(1));
                    end
                    if (closes)
                    begin
                        flags_next.phase          = jaos_pkg::PH_SCAN;
                        flags_next.inside_string  = 1'b0;
                        flags_next.escape_pending = 1'b0;
                    end
                end
            end
        endcase

        // copy or drop the byte
        if (byte_path)
        begin
            if ((cnt_base_ext < max_ext) && (cnt_base != COUNT_MAX))
            begin
                byte_count_next        = cnt_inc;
                has_result             = 1'b1;
                result.kind            = jaos_pkg::KIND_BYTE;
                result.data            = b;
                result.first           = is_first;
                result.last            = closes;
                result.closed_by_brace = closes;
                result.copied_length   = cnt_inc_ext[jaos_pkg::COPIED_W-1:0];
                result.truncated       = flags_next.dropped_flag;
            end
            else
            begin
                flags_next.dropped_flag = 1'b1;
                if (closes)
                begin
                    has_result             = 1'b1;
                    result.kind            = jaos_pkg::KIND_END;
                    result.last            = 1'b1;
                    result.closed_by_brace = 1'b1;
                    result.copied_length   = cnt_base_ext[jaos_pkg::COPIED_W-1:0];
                    result.truncated       = 1'b1;
                end
            end
        end
    end

    assign cnt_inc      = cnt_base + LEN_BITS'(1);
    assign cnt_base_ext = CMP_W'(cnt_base);
    assign cnt_inc_ext  = CMP_W'(cnt_inc);
    assign max_ext      = CMP_W'(max_copy_len);

endmodule

FILE: design/json_array_object_splitter_core.sv
// top level of the json array object splitter: input register, parser state, result register
// Takes JSON array text one byte per transaction and returns the bytes of each top-level
// object, at most max_copy_len per object; an object ends on a last-flagged byte or an end
// marker, and the array on a no-more-objects marker. One byte is accepted every cycle unless
// a result waits on a stalled output; an accepted byte lands in the input register, and its
// result goes into the result register when stage 1 moves on; bytes that give no result
// still pass through the input register. Throughput is set by the combinational parser
// step, whose brace depth and byte count feed back into the next byte.
// max_copy_len is written through the cfg channel, which is always ready.
module json_array_object_splitter_core #(
    parameter int DEPTH_BITS = jaos_pkg::DEPTH_BITS_DEF,
    parameter int LEN_BITS   = jaos_pkg::LEN_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [jaos_pkg::BYTE_W-1:0]       in_byte,
    input  logic                              end_of_input,
    input  logic                              restart,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [jaos_pkg::KIND_W-1:0]       kind,
    output logic [jaos_pkg::BYTE_W-1:0]       data,
    output logic                              first,
    output logic                              last,
    output logic [jaos_pkg::COPIED_W-1:0]     copied_length,
    output logic                              truncated,
    output logic                              closed_by_brace,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [jaos_pkg::CFG_W-1:0]        cfg_data
);

    logic [jaos_pkg::CFG_W-1:0] max_copy_len_reg;
    logic                       s1_valid_reg;
    jaos_pkg::item_t            s1_item_reg;
    jaos_pkg::flags_t           flags_reg;
    jaos_pkg::flags_t           flags_next;
    logic [DEPTH_BITS-1:0]      depth_reg;
    logic [DEPTH_BITS-1:0]      depth_next;
    logic [LEN_BITS-1:0]        count_reg;
    logic [LEN_BITS-1:0]        count_next;
    logic                       has_result;
    jaos_pkg::result_t          result;
    logic                       out_valid_reg;
    jaos_pkg::result_t          out_reg;
    logic                       s1_go;
    jaos_pkg::item_t            in_item;

    assign in_item.in_byte      = in_byte;
    assign in_item.end_of_input = end_of_input;
    assign in_item.restart      = restart;

    jaos_step #(
        .DEPTH_BITS (DEPTH_BITS),
        .LEN_BITS   (LEN_BITS)
    ) u_step (
        .item             (s1_item_reg),
        .max_copy_len     (max_copy_len_reg),
        .flags            (flags_reg),
        .brace_depth      (depth_reg),
        .byte_count       (count_reg),
        .flags_next       (flags_next),
        .brace_depth_next (depth_next),
        .byte_count_next  (count_next),
        .has_result       (has_result),
        .result           (result)
    );

    // stage 1 moves on unless its result would land on a full, stalled result register
    assign s1_go    = s1_valid_reg && (!has_result || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_go;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_copy_len_reg         <= jaos_pkg::MAX_COPY_RESET;
            s1_valid_reg             <= 1'b0;
            out_valid_reg            <= 1'b0;
            flags_reg.phase          <= jaos_pkg::PH_SCAN;
            flags_reg.inside_string  <= 1'b0;
            flags_reg.escape_pending <= 1'b0;
            flags_reg.dropped_flag   <= 1'b0;
            depth_reg                <= '0;
            count_reg                <= '0;
        end
        else
        begin
            if (cfg_valid)
                max_copy_len_reg <= cfg_data;
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (s1_go)
            begin
                flags_reg <= flags_next;
                depth_reg <= depth_next;
                count_reg <= count_next;
            end
            if (s1_go && has_result)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            s1_item_reg <= in_item;
        if (s1_go && has_result)
            out_reg <= result;
    end

    assign out_valid       = out_valid_reg;
    assign kind            = out_reg.kind;
    assign data            = out_reg.data;
    assign first           = out_reg.first;
    assign last            = out_reg.last;
    assign copied_length   = out_reg.copied_length;
    assign truncated       = out_reg.truncated;
    assign closed_by_brace = out_reg.closed_by_brace;

endmodule
